// ----- hdl/ats_pkg.sv -----
`timescale 1ns / 1ps

package ats_pkg;

  localparam int SLOTS_DEF     = 8;
  localparam int TIME_BITS_DEF = 40;

  localparam int TAG_W    = 16;
  localparam int STALE_W  = 16;
  localparam int PER_W    = 20;
  localparam int OP_W     = 2;
  localparam int CLR_W    = 4;
  localparam int OUT_W    = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_STALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;

  localparam logic [STALE_W-1:0] STALE_RST  = 16'd3600;
  localparam logic [PER_W-1:0]   PERIOD_RST = 20'd86400;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_CHECK = 2'd1,
    OP_POP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

endpackage

// ----- hdl/alarm_table_due_scheduler_unit.sv -----
`timescale 1ns / 1ps

// channel   | direction | beat contents
// s_axis    | in        | tdata: op[1:0], time_value, repeat_daily, msg_tag, zero pad
// m_axis    | out       | tdata: ok, tag_out, cleared_count, zero pad
// cfg       | in        | index 0 stale_limit, index 1 repeat_period
//
// add and clear need no scan; check scans every slot for the earliest due one
// pop scans the same way, scans again for each stale one-shot dropped, and runs a
// bit-serial remainder when a daily alarm is advanced
// the slot scan reads the slot memory (one read a cycle); the engine takes one command at a time
// reset clears all slots at once (active marks are flops), config back to defaults
// a two-beat command queue keeps taking input while the engine or output stalls, until it is full

module alarm_table_due_scheduler_unit #(
  parameter int SLOTS     = ats_pkg::SLOTS_DEF,
  parameter int TIME_BITS = ats_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // op, time_value, repeat_daily, msg_tag from bit 0 up
  input  logic [((TIME_BITS+26)/8)*8-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // ok, tag_out, cleared_count from bit 0 up
  output logic [ats_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ats_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ats_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IN_W = ((TIME_BITS + 26) / 8) * 8;

  logic                        cmd_valid, cmd_ready;
  ats_pkg::op_e                cmd_op;
  logic [TIME_BITS-1:0]        cmd_time;
  logic                        cmd_daily;
  logic [ats_pkg::TAG_W-1:0]   cmd_tag;
  logic [ats_pkg::STALE_W-1:0] stale_q;
  logic [ats_pkg::PER_W-1:0]   period_q;
  logic                        out_ok;
  logic [ats_pkg::TAG_W-1:0]   out_tag;
  logic [ats_pkg::CLR_W-1:0]   out_cnt;

  // config writes are for the user to make only while idle; not enforced here, so always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q  <= ats_pkg::STALE_RST;
      period_q <= ats_pkg::PERIOD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ats_pkg::REG_STALE:  stale_q  <= cfg_data_i[ats_pkg::STALE_W-1:0];
        ats_pkg::REG_PERIOD: period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ats_front #(
    .TIME_BITS (TIME_BITS),
    .IN_W      (IN_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_op_o    (cmd_op),
    .cmd_time_o  (cmd_time),
    .cmd_daily_o (cmd_daily),
    .cmd_tag_o   (cmd_tag)
  );

  ats_back #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_op_i        (cmd_op),
    .cmd_time_i      (cmd_time),
    .cmd_daily_i     (cmd_daily),
    .cmd_tag_i       (cmd_tag),
    .stale_limit_i   (stale_q),
    .repeat_period_i (period_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_ok_o        (out_ok),
    .out_tag_o       (out_tag),
    .out_cnt_o       (out_cnt)
  );

  assign m_axis_tdata = {3'b000, out_cnt, out_tag, out_ok};

endmodule

// ----- hdl/ats_front.sv -----
`timescale 1ns / 1ps

module ats_front #(
  parameter int TIME_BITS = ats_pkg::TIME_BITS_DEF,
  parameter int IN_W      = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [IN_W-1:0]           in_data_i,
  output logic                      cmd_valid_o,
  input  logic                      cmd_ready_i,
  output ats_pkg::op_e              cmd_op_o,
  output logic [TIME_BITS-1:0]      cmd_time_o,
  output logic                      cmd_daily_o,
  output logic [ats_pkg::TAG_W-1:0] cmd_tag_o
);

  localparam int ENT_W = ats_pkg::OP_W + TIME_BITS + 1 + ats_pkg::TAG_W;

  logic [ENT_W-1:0]          ent_q [ats_pkg::QDEPTH];
  logic [ats_pkg::QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [ats_pkg::QPTR_W:0]   cnt_q, cnt_d;
  logic                       push, pop;
  logic [ENT_W-1:0]           head;

  assign in_ready_o  = (cnt_q != (ats_pkg::QPTR_W+1)'(ats_pkg::QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign push        = in_valid_i & in_ready_o;
  assign pop         = cmd_valid_o & cmd_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= in_data_i[ENT_W-1:0];
    end
  end

  // classify the head beat into its fields
  assign head        = ent_q[rd_q];
  assign cmd_op_o    = ats_pkg::op_e'(head[ats_pkg::OP_W-1:0]);
  assign cmd_time_o  = head[ats_pkg::OP_W +: TIME_BITS];
  assign cmd_daily_o = head[ats_pkg::OP_W + TIME_BITS];
  assign cmd_tag_o   = head[ats_pkg::OP_W + TIME_BITS + 1 +: ats_pkg::TAG_W];

endmodule

// ----- hdl/ats_back.sv -----
`timescale 1ns / 1ps

module ats_back #(
  parameter int SLOTS     = ats_pkg::SLOTS_DEF,
  parameter int TIME_BITS = ats_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  ats_pkg::op_e                cmd_op_i,
  input  logic [TIME_BITS-1:0]        cmd_time_i,
  input  logic                        cmd_daily_i,
  input  logic [ats_pkg::TAG_W-1:0]   cmd_tag_i,
  input  logic [ats_pkg::STALE_W-1:0] stale_limit_i,
  input  logic [ats_pkg::PER_W-1:0]   repeat_period_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_ok_o,
  output logic [ats_pkg::TAG_W-1:0]   out_tag_o,
  output logic [ats_pkg::CLR_W-1:0]   out_cnt_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ENT_W = TIME_BITS + ats_pkg::TAG_W + 1;
  localparam int REM_W = ats_pkg::PER_W + 1;
  localparam int BIT_W = $clog2(TIME_BITS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_UPD    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [SLOTS-1:0]            act_q, act_d;
  ats_pkg::op_e                op_q, op_d;
  logic [TIME_BITS-1:0]        now_q, now_d;
  logic [CNT_W-1:0]            scan_q, scan_d;
  logic                        pend_q, pend_d;
  logic [IDX_W-1:0]            pidx_q, pidx_d;
  logic                        found_q, found_d;
  logic [IDX_W-1:0]            best_q, best_d;
  logic [TIME_BITS-1:0]        bdue_q, bdue_d;
  logic [ats_pkg::TAG_W-1:0]   btag_q, btag_d;
  logic                        bdaily_q, bdaily_d;
  logic [TIME_BITS-1:0]        div_q, div_d;
  logic [REM_W-1:0]            rem_q, rem_d;
  logic [BIT_W-1:0]            bits_q, bits_d;
  logic                        rok_q, rok_d;
  logic [ats_pkg::TAG_W-1:0]   rtag_q, rtag_d;
  logic [ats_pkg::CLR_W-1:0]   rcnt_q, rcnt_d;
  logic                        ov_q, ov_d;
  logic                        ook_q;
  logic [ats_pkg::TAG_W-1:0]   otag_q;
  logic [ats_pkg::CLR_W-1:0]   ocnt_q;

  // slot store: due time, tag and daily mark; active marks live in flops
  logic [ENT_W-1:0]            mem [SLOTS];
  logic [ENT_W-1:0]            rd_q;
  logic [IDX_W-1:0]            rd_addr;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_wa;
  logic [ENT_W-1:0]            mem_wd;

  logic [ats_pkg::PER_W-1:0]   per;
  logic                        free_ok;
  logic [IDX_W-1:0]            free_idx;
  logic [CNT_W-1:0]            act_cnt;
  logic [7:0]                  cnt8;
  logic [ats_pkg::CLR_W-1:0]   clr_cnt;
  logic                        issue;
  logic [TIME_BITS-1:0]        e_due;
  logic [ats_pkg::TAG_W-1:0]   e_tag;
  logic                        e_daily;
  logic                        late;
  logic [REM_W-1:0]            rem_sh;
  logic [TIME_BITS-1:0]        base;
  logic [TIME_BITS:0]          sum;
  logic [TIME_BITS-1:0]        new_due;
  logic                        load_out;

  assign per = (repeat_period_i == '0) ? ats_pkg::PER_W'(1) : repeat_period_i;

  // lowest free slot and active count
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    act_cnt  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(i);
      end
      act_cnt = act_cnt + CNT_W'(act_q[i]);
    end
  end

  assign cnt8    = 8'(act_cnt);
  assign clr_cnt = (cnt8 > 8'd15) ? 4'hF : cnt8[ats_pkg::CLR_W-1:0];

  assign issue   = (scan_q < CNT_W'(SLOTS));
  assign rd_addr = issue ? scan_q[IDX_W-1:0] : '0;
  assign e_due   = rd_q[TIME_BITS-1:0];
  assign e_tag   = rd_q[TIME_BITS +: ats_pkg::TAG_W];
  assign e_daily = rd_q[ENT_W-1];

  assign late    = (now_q - bdue_q) > TIME_BITS'(stale_limit_i);
  assign rem_sh  = {rem_q[REM_W-2:0], div_q[TIME_BITS-1]};
  assign base    = now_q - TIME_BITS'(rem_q);
  assign sum     = {1'b0, base} + (TIME_BITS+1)'(per);
  assign new_due = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

  assign cmd_ready_o = (state_q == S_IDLE);
  assign load_out    = (state_q == S_OUT) && (!ov_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    op_d     = op_q;
    now_d    = now_q;
    scan_d   = scan_q;
    pend_d   = pend_q;
    pidx_d   = pidx_q;
    found_d  = found_q;
    best_d   = best_q;
    bdue_d   = bdue_q;
    btag_d   = btag_q;
    bdaily_d = bdaily_q;
    div_d    = div_q;
    rem_d    = rem_q;
    bits_d   = bits_q;
    rok_d    = rok_q;
    rtag_d   = rtag_q;
    rcnt_d   = rcnt_q;
    mem_we   = 1'b0;
    mem_wa   = best_q;
    mem_wd   = {bdaily_q, btag_q, new_due};
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          op_d   = cmd_op_i;
          now_d  = cmd_time_i;
          rok_d  = 1'b0;
          rtag_d = '0;
          rcnt_d = '0;
          case (cmd_op_i)
            ats_pkg::OP_ADD: begin
              if (free_ok) begin
                mem_we          = 1'b1;
                mem_wa          = free_idx;
                mem_wd          = {cmd_daily_i, cmd_tag_i, cmd_time_i};
                act_d[free_idx] = 1'b1;
                rok_d           = 1'b1;
              end
              state_d = S_OUT;
            end
            ats_pkg::OP_CLEAR: begin
              act_d   = '0;
              rcnt_d  = clr_cnt;
              state_d = S_OUT;
            end
            default: begin
              scan_d  = '0;
              pend_d  = 1'b0;
              found_d = 1'b0;
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        pend_d = issue;
        pidx_d = rd_addr;
        if (issue) begin
          scan_d = scan_q + 1'b1;
        end
        if (pend_q && act_q[pidx_q] && (e_due <= now_q) && (!found_q || e_due < bdue_q)) begin
          found_d  = 1'b1;
          best_d   = pidx_q;
          bdue_d   = e_due;
          btag_d   = e_tag;
          bdaily_d = e_daily;
        end
        if (!issue && !pend_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (op_q == ats_pkg::OP_CHECK || !found_q) begin
          rok_d   = found_q;
          state_d = S_OUT;
        end else if (!bdaily_q && late) begin
          // stale one-shot: drop silently and search again
          act_d[best_q] = 1'b0;
          scan_d        = '0;
          pend_d        = 1'b0;
          found_d       = 1'b0;
          state_d       = S_SCAN;
        end else if (bdaily_q) begin
          div_d   = now_q - bdue_q;
          rem_d   = '0;
          bits_d  = BIT_W'(TIME_BITS);
          state_d = S_DIV;
        end else begin
          act_d[best_q] = 1'b0;
          rok_d         = 1'b1;
          rtag_d        = btag_q;
          state_d       = S_OUT;
        end
      end
      S_DIV: begin
        rem_d  = (rem_sh >= REM_W'(per)) ? rem_sh - REM_W'(per) : rem_sh;
        div_d  = div_q << 1;
        bits_d = bits_q - 1'b1;
        if (bits_q == BIT_W'(1)) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        mem_we  = 1'b1;
        rok_d   = 1'b1;
        rtag_d  = btag_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (load_out) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= '0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      bits_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      bits_q  <= bits_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    now_q    <= now_d;
    pidx_q   <= pidx_d;
    best_q   <= best_d;
    bdue_q   <= bdue_d;
    btag_q   <= btag_d;
    bdaily_q <= bdaily_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
    rok_q    <= rok_d;
    rtag_q   <= rtag_d;
    rcnt_q   <= rcnt_d;
    if (load_out) begin
      ook_q  <= rok_q;
      otag_q <= rtag_q;
      ocnt_q <= rcnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  assign out_valid_o = ov_q;
  assign out_ok_o    = ook_q;
  assign out_tag_o   = otag_q;
  assign out_cnt_o   = ocnt_q;

  a_best_due : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && found_q) |-> (bdue_q <= now_q))
    else $error("chosen slot is not due");

  a_best_act : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && found_q) |-> act_q[best_q])
    else $error("chosen slot is not active");

  a_rem_rng : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_UPD) |-> (rem_q < REM_W'(per)))
    else $error("period remainder out of range");

  a_add_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && cmd_valid_i && cmd_op_i == ats_pkg::OP_ADD && free_ok)
    |=> act_q[$past(free_idx)])
    else $error("added slot not marked active");

endmodule

// ----- tb/alarm_table_checker.sv -----
`timescale 1ns / 1ps

module alarm_table_checker (
  input  logic        clk_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  output int          errors_o,
  output int          waiting_o
);
  import ats_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam logic [39:0] TMAX = '1;

  typedef struct packed {
    logic        ok;
    logic [15:0] tag;
    logic [3:0]  cnt;
  } answer_t;

  answer_t answer_q[$];

  bit          act[NSLOT];
  bit          dly[NSLOT];
  logic [39:0] due[NSLOT];
  logic [15:0] tags[NSLOT];
  logic [15:0] stale;
  logic [19:0] period;

  initial begin
    errors_o  = 0;
    waiting_o = 0;
    stale     = STALE_RST;
    period    = PERIOD_RST;
    for (int i = 0; i < NSLOT; i++) begin
      act[i] = 0; dly[i] = 0; due[i] = '0; tags[i] = '0;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors_o++;
    if (errors_o <= 40) $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  function automatic int earliest_due(input logic [39:0] now);
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if (act[i] && due[i] <= now && (best < 0 || due[i] < due[best])) best = i;
    return best;
  endfunction

  // push a daily slot past now by whole periods, saturating at the top of time
  function automatic void roll_daily(input int s, input logic [39:0] now);
    logic [63:0] per, diff, base;
    per  = (period == 0) ? 64'd1 : {44'd0, period};
    diff = {24'd0, now} - {24'd0, due[s]};
    base = {24'd0, due[s]} + (diff - diff % per);
    if (per > {24'd0, TMAX} - base) due[s] = TMAX;
    else due[s] = 40'(base + per);
  endfunction

  function automatic answer_t predict_command(input logic [63:0] beat);
    answer_t     a;
    op_e         op;
    logic [39:0] t;
    int          b, n;
    a  = '0;
    op = op_e'(beat[1:0]);
    t  = beat[41:2];
    case (op)
      OP_ADD: begin
        for (int i = 0; i < NSLOT; i++)
          if (!act[i]) begin
            act[i] = 1; due[i] = t; dly[i] = beat[42]; tags[i] = beat[58:43];
            a.ok = 1;
            break;
          end
      end
      OP_CHECK: a.ok = earliest_due(t) >= 0;
      OP_POP: begin
        for (int p = 0; p <= NSLOT; p++) begin
          b = earliest_due(t);
          if (b < 0) break;
          // stale one-shot: drop silently and look again
          if (!dly[b] && (t - due[b]) > {24'd0, stale}) begin
            act[b] = 0;
            continue;
          end
          a.ok  = 1;
          a.tag = tags[b];
          if (dly[b]) roll_daily(b, t);
          else act[b] = 0;
          break;
        end
      end
      default: begin
        n = 0;
        for (int i = 0; i < NSLOT; i++)
          if (act[i]) begin act[i] = 0; n++; end
        a.cnt = (n > 15) ? 4'd15 : 4'(n);
      end
    endcase
    return a;
  endfunction

  always @(posedge clk_i) begin
    answer_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      // beat holds ok at bit 0, tag_out above it, cleared_count on top
      got = {m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[20:17]};
      if (answer_q.size() == 0) begin
        report("unexpected beat", 32'(got), 32'd0);
      end else begin
        want = answer_q.pop_front();
        if (got.ok !== want.ok) report("ok", 32'(got.ok), 32'(want.ok));
        if (got.tag !== want.tag) report("tag_out", 32'(got.tag), 32'(want.tag));
        if (got.cnt !== want.cnt) report("cleared_count", 32'(got.cnt), 32'(want.cnt));
      end
    end
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_STALE) stale = cfg_data_i[15:0];
      else if (cfg_index_i == REG_PERIOD) period = cfg_data_i;
    end
    if (s_axis_tvalid && s_axis_tready) answer_q.push_back(predict_command(s_axis_tdata));
    waiting_o = answer_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ats_pkg::*;

  localparam logic [39:0] TMAX = '1;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [19:0] cfg_data_i = '0;

  int          errors, waiting;
  int          idle_cycles = 0;
  bit          calm = 0;      // no gaps and no stalls while set
  int          stall_left = 0;
  logic [39:0] now;

  always #5 clk_i = ~clk_i;

  alarm_table_due_scheduler_unit dut (.*);

  alarm_table_checker chk (
    .clk_i, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .waiting_o(waiting)
  );

  // result side: random stall before each beat, none while calm
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) stall_left = calm ? 0 : $urandom_range(0, 7);
    if (stall_left > 0) begin
      m_axis_tready <= 0;
      stall_left--;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  // watchdog: cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= 3000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // valid stays high across back-to-back beats; this task lowers it only for a gap
  task automatic send_command(input op_e op, input logic [39:0] t, input bit daily,
                              input logic [15:0] tag);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {5'd0, tag, daily, t, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // only with the table idle: drain, let a late pop finish, then write
  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  // mostly times near a moving clock so alarms come due, go stale and repeat
  task automatic random_phase(input int n);
    int r;
    logic [39:0] t;
    for (int k = 0; k < n; k++) begin
      if (k % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        t = now + 40'($urandom_range(0, 8000)) - 40'd4000;
        send_command(OP_ADD, t, $urandom_range(0, 2) == 0, 16'($urandom));
      end else if (r < 50) begin
        send_command(OP_CHECK, now, 1'($urandom), 16'($urandom));
      end else if (r < 85) begin
        now += 40'($urandom_range(0, 3000));
        send_command(OP_POP, now, 1'($urandom), 16'($urandom));
      end else if (r < 88) begin
        send_command(OP_CLEAR, 40'({$urandom, $urandom}), 1'($urandom), 16'($urandom));
      end else if (r < 97) begin
        send_command(op_e'($urandom_range(0, 3)), 40'({$urandom, $urandom}),
                     1'($urandom), 16'($urandom));
      end else begin
        // jump close to the top of time to reach saturation and wrap
        now = TMAX - 40'($urandom_range(0, 200000));
        send_command(OP_POP, now, 0, 16'($urandom));
      end
    end
  endtask

  initial begin
    now = 40'd10000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: fill past full, extremes of time and tag, every op
    calm = 1;
    send_command(OP_CHECK, 40'd0, 0, 16'h0000);
    send_command(OP_POP, 40'd0, 0, 16'h0000);
    send_command(OP_ADD, 40'd0, 0, 16'hFFFF);
    send_command(OP_ADD, TMAX, 1, 16'h0001);
    for (int i = 0; i < 7; i++) send_command(OP_ADD, 40'd5000 + 40'(i), i[0], 16'(i + 2));
    send_command(OP_CHECK, 40'd0, 0, 0);
    send_command(OP_POP, 40'd0, 0, 0);
    send_command(OP_POP, 40'd9000, 0, 0);     // one-shot 4000 late: dropped, daily fires
    send_command(OP_POP, 40'd5004, 0, 0);
    send_command(OP_POP, TMAX, 0, 0);         // daily at the top saturates
    send_command(OP_CLEAR, 40'd0, 0, 0);
    send_command(OP_CLEAR, 40'd0, 0, 0);
    send_command(OP_ADD, TMAX - 40'd10, 1, 16'hA5A5);
    send_command(OP_POP, TMAX, 0, 0);
    send_command(OP_CHECK, TMAX, 0, 0);
    send_command(OP_CLEAR, TMAX, 1, 16'hFFFF);
    calm = 0;

    random_phase(330);
    write_reg(REG_STALE, 20'd0);
    write_reg(REG_PERIOD, 20'd1);
    random_phase(340);
    write_reg(REG_STALE, 20'hFFFF);
    write_reg(REG_PERIOD, 20'hFFFFF);
    random_phase(340);
    write_reg(REG_PERIOD, 20'd0);             // zero period acts as one
    write_reg(REG_STALE, 20'd100);
    random_phase(340);
    write_reg(REG_STALE, 20'($urandom_range(0, 65535)));
    write_reg(REG_PERIOD, 20'($urandom_range(1, 5000)));
    random_phase(380);

    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ats_pkg.sv
hdl/ats_front.sv
hdl/ats_back.sv
hdl/alarm_table_due_scheduler_unit.sv
tb/alarm_table_checker.sv
tb/tb.sv
